>>> design/sample_record_min_max_mean_assert.svh
// Assertion macros shared by the sample recorder modules.
`ifndef SAMPLE_RECORD_MIN_MAX_MEAN_ASSERT_SVH
`define SAMPLE_RECORD_MIN_MAX_MEAN_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define SRMMM_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define SRMMM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define SRMMM_ASSERT(lbl, prop, msg)
`define SRMMM_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

>>> design/srmmm_pkg.sv
// Shared constants of the sample recorder.
package srmmm_pkg;

    localparam int SAMPLE_BITS   = 12;
    localparam int COUNT_BITS    = 8;
    localparam int DEPTH_DEFAULT = 128;

    localparam logic OP_RECORD = 1'b0;
    localparam logic OP_CLEAR  = 1'b1;

endpackage

>>> design/srmmm_ram.sv
// Generic single-write, single-read RAM with registered read data.
module srmmm_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> design/srmmm_div.sv
// Bit-serial restoring divider, one quotient bit per cycle.
`include "sample_record_min_max_mean_assert.svh"

module srmmm_div #(
    parameter int DIVIDEND_W = 20,
    parameter int DIVISOR_W  = 8,
    parameter int QUOT_W     = 12
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [DIVIDEND_W-1:0] dividend,
    input  logic [DIVISOR_W-1:0]  divisor,
    output logic                  busy,
    output logic                  done,
    output logic [QUOT_W-1:0]     quotient
);

    localparam int STEP_W = (DIVIDEND_W > 1) ? $clog2(DIVIDEND_W) : 1;

    logic                  busy_reg;
    logic                  done_reg;
    logic [STEP_W-1:0]     step_reg;
    logic [DIVIDEND_W-1:0] quo_reg;
    logic [DIVISOR_W-1:0]  rem_reg;
    logic [DIVISOR_W-1:0]  divisor_reg;

    logic [DIVISOR_W:0]    trial;
    logic                  trial_ge;
    logic [DIVISOR_W-1:0]  rem_next;
    logic [DIVIDEND_W-1:0] quo_next;

    // The dividend shifts out of the top of the quotient register as the
    // quotient bits shift in at the bottom.
    always_comb
    begin
        trial    = {rem_reg, quo_reg[DIVIDEND_W-1]};
        trial_ge = (trial >= {1'b0, divisor_reg});
        rem_next = trial_ge ? DIVISOR_W'(trial - {1'b0, divisor_reg})
                            : trial[DIVISOR_W-1:0];
        quo_next = {quo_reg[DIVIDEND_W-2:0], trial_ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            step_reg <= STEP_W'(DIVIDEND_W - 1);
        end
        else if (busy_reg)
        begin
            if (step_reg == '0)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
            else
            begin
                step_reg <= step_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg     <= dividend;
            rem_reg     <= '0;
            divisor_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

    assign busy     = busy_reg;
    assign done     = done_reg;
    assign quotient = quo_reg[QUOT_W-1:0];

    `SRMMM_ASSERT(a_rem_below_divisor, !busy_reg || divisor_reg == '0 || rem_reg < divisor_reg, "divider remainder not below divisor")
    `SRMMM_ASSERT_NEXT(a_last_step_done, busy_reg && !start && step_reg == '0, !busy_reg && done_reg, "divider did not finish after last step")
    `SRMMM_ASSERT(a_busy_done_apart, !(busy_reg && done_reg), "divider busy and done together")

endmodule

>>> design/sample_record_min_max_mean.sv
// Top level of the two-channel sample recorder with min, max and window mean.
//
//  channel | signals                      | direction | accepted when
//  --------+------------------------------+-----------+----------------------
//  input   | opcode, sample_a, sample_b   | in        | in_valid && in_ready
//  result  | count, max_a .. mean_b       | out       | out_valid && out_ready
//
// A record item passes through S_UPD, S_DIV and S_FIN before the next acceptance;
// in S_DIV the bit-serial divider forms each channel's mean one quotient bit
// per cycle. A clear item goes from S_IDLE straight to S_FIN.
// Reset clears the count, pointer, sums and extremes at once; the history RAM
// is not cleared, since an entry is read only after it has been written.
// A finished result sits in the output register, and the next item is
// accepted while it waits; a following result waits for that register.
`include "sample_record_min_max_mean_assert.svh"

module sample_record_min_max_mean #(
    parameter int DEPTH = srmmm_pkg::DEPTH_DEFAULT
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic                             opcode,
    input  logic [srmmm_pkg::SAMPLE_BITS-1:0] sample_a,
    input  logic [srmmm_pkg::SAMPLE_BITS-1:0] sample_b,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [srmmm_pkg::COUNT_BITS-1:0]  count,
    output logic [srmmm_pkg::SAMPLE_BITS-1:0] max_a,
    output logic [srmmm_pkg::SAMPLE_BITS-1:0] min_a,
    output logic [srmmm_pkg::SAMPLE_BITS-1:0] mean_a,
    output logic [srmmm_pkg::SAMPLE_BITS-1:0] max_b,
    output logic [srmmm_pkg::SAMPLE_BITS-1:0] min_b,
    output logic [srmmm_pkg::SAMPLE_BITS-1:0] mean_b
);

    localparam int SB    = srmmm_pkg::SAMPLE_BITS;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int SUM_W = SB + CNT_W;

    typedef enum logic [1:0] {
        S_IDLE,
        S_UPD,
        S_DIV,
        S_FIN
    } state_t;

    state_t           state_reg;
    logic [PTR_W-1:0] wp_reg;
    logic [CNT_W-1:0] count_reg;
    logic [SUM_W-1:0] sum_a_reg;
    logic [SUM_W-1:0] sum_b_reg;
    logic [SB-1:0]    largest_a_reg;
    logic [SB-1:0]    smallest_a_reg;
    logic [SB-1:0]    largest_b_reg;
    logic [SB-1:0]    smallest_b_reg;
    logic [SB-1:0]    samp_a_reg;
    logic [SB-1:0]    samp_b_reg;

    logic                            out_valid_reg;
    logic [srmmm_pkg::COUNT_BITS-1:0] count_out_reg;
    logic [SB-1:0]                   max_a_reg;
    logic [SB-1:0]                   min_a_reg;
    logic [SB-1:0]                   mean_a_reg;
    logic [SB-1:0]                   max_b_reg;
    logic [SB-1:0]                   min_b_reg;
    logic [SB-1:0]                   mean_b_reg;

    logic             in_accept;
    logic             out_free;
    logic             full;
    logic [2*SB-1:0]  old_pair;
    logic [SUM_W-1:0] sum_a_next;
    logic [SUM_W-1:0] sum_b_next;
    logic [CNT_W-1:0] count_next;
    logic [PTR_W-1:0] wp_next;
    logic             div_start;
    logic             div_busy_a;
    logic             div_busy_b;
    logic             div_done_a;
    logic             div_done_b;
    logic [SB-1:0]    quot_a;
    logic [SB-1:0]    quot_b;
    logic [31:0]      count_wide;
    logic             nonzero;

    assign in_ready  = (state_reg == S_IDLE);
    assign in_accept = in_valid && in_ready;
    assign out_free  = !out_valid_reg || out_ready;
    assign full      = (count_reg == CNT_W'(DEPTH));
    assign div_start = (state_reg == S_UPD);

    // The history holds both channels side by side; the oldest pair is read
    // at the write pointer when the item is accepted and is ready in the next
    // cycle, in S_UPD, where it is overwritten by the new pair.
    srmmm_ram #(
        .WIDTH (2 * SB),
        .DEPTH (DEPTH)
    ) u_history (
        .clk     (clk),
        .wr_en   (div_start),
        .wr_addr (wp_reg),
        .wr_data ({samp_a_reg, samp_b_reg}),
        .rd_en   (in_accept),
        .rd_addr (wp_reg),
        .rd_data (old_pair)
    );

    // Once the window is full the oldest sample leaves the running sum as the
    // new one enters it, and the count stays at the depth.
    always_comb
    begin
        if (full)
        begin
            sum_a_next = sum_a_reg - SUM_W'(old_pair[2*SB-1:SB]) + SUM_W'(samp_a_reg);
            sum_b_next = sum_b_reg - SUM_W'(old_pair[SB-1:0]) + SUM_W'(samp_b_reg);
            count_next = count_reg;
        end
        else
        begin
            sum_a_next = sum_a_reg + SUM_W'(samp_a_reg);
            sum_b_next = sum_b_reg + SUM_W'(samp_b_reg);
            count_next = count_reg + 1'b1;
        end
        wp_next = (wp_reg == PTR_W'(DEPTH - 1)) ? '0 : wp_reg + 1'b1;
    end

    // Both channels divide at the same time with the same divisor, so they
    // finish together.
    srmmm_div #(
        .DIVIDEND_W (SUM_W),
        .DIVISOR_W  (CNT_W),
        .QUOT_W     (SB)
    ) u_div_a (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (sum_a_next),
        .divisor  (count_next),
        .busy     (div_busy_a),
        .done     (div_done_a),
        .quotient (quot_a)
    );

    srmmm_div #(
        .DIVIDEND_W (SUM_W),
        .DIVISOR_W  (CNT_W),
        .QUOT_W     (SB)
    ) u_div_b (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (sum_b_next),
        .divisor  (count_next),
        .busy     (div_busy_b),
        .done     (div_done_b),
        .quotient (quot_b)
    );

    // An empty record reports zero for every extreme and mean; the count is
    // reported in its eight-bit field.
    assign count_wide = 32'(count_reg);
    assign nonzero    = (count_reg != '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            wp_reg         <= '0;
            count_reg      <= '0;
            sum_a_reg      <= '0;
            sum_b_reg      <= '0;
            largest_a_reg  <= '0;
            smallest_a_reg <= '1;
            largest_b_reg  <= '0;
            smallest_b_reg <= '1;
            out_valid_reg  <= 1'b0;
            count_out_reg  <= '0;
            max_a_reg      <= '0;
            min_a_reg      <= '0;
            mean_a_reg     <= '0;
            max_b_reg      <= '0;
            min_b_reg      <= '0;
            mean_b_reg     <= '0;
        end
        else
        begin
            // A new result takes the output register as soon as it is free;
            // otherwise an accepted result empties it.
            if (state_reg == S_FIN && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (in_accept)
                    begin
                        if (opcode == srmmm_pkg::OP_CLEAR)
                        begin
                            wp_reg         <= '0;
                            count_reg      <= '0;
                            sum_a_reg      <= '0;
                            sum_b_reg      <= '0;
                            largest_a_reg  <= '0;
                            smallest_a_reg <= '1;
                            largest_b_reg  <= '0;
                            smallest_b_reg <= '1;
                            state_reg      <= S_FIN;
                        end
                        else
                        begin
                            state_reg <= S_UPD;
                        end
                    end
                end
                S_UPD:
                begin
                    sum_a_reg <= sum_a_next;
                    sum_b_reg <= sum_b_next;
                    count_reg <= count_next;
                    wp_reg    <= wp_next;
                    if (samp_a_reg > largest_a_reg)
                    begin
                        largest_a_reg <= samp_a_reg;
                    end
                    if (samp_a_reg < smallest_a_reg)
                    begin
                        smallest_a_reg <= samp_a_reg;
                    end
                    if (samp_b_reg > largest_b_reg)
                    begin
                        largest_b_reg <= samp_b_reg;
                    end
                    if (samp_b_reg < smallest_b_reg)
                    begin
                        smallest_b_reg <= samp_b_reg;
                    end
                    state_reg <= S_DIV;
                end
                S_DIV:
                begin
                    if (div_done_a && div_done_b && !div_busy_a && !div_busy_b)
                    begin
                        state_reg <= S_FIN;
                    end
                end
                S_FIN:
                begin
                    if (out_free)
                    begin
                        count_out_reg <= count_wide[srmmm_pkg::COUNT_BITS-1:0];
                        max_a_reg     <= nonzero ? largest_a_reg  : '0;
                        min_a_reg     <= nonzero ? smallest_a_reg : '0;
                        mean_a_reg    <= nonzero ? quot_a         : '0;
                        max_b_reg     <= nonzero ? largest_b_reg  : '0;
                        min_b_reg     <= nonzero ? smallest_b_reg : '0;
                        mean_b_reg    <= nonzero ? quot_b         : '0;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // The accepted samples are held while the item is processed.
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            samp_a_reg <= sample_a;
            samp_b_reg <= sample_b;
        end
    end

    assign out_valid = out_valid_reg;
    assign count     = count_out_reg;
    assign max_a     = max_a_reg;
    assign min_a     = min_a_reg;
    assign mean_a    = mean_a_reg;
    assign max_b     = max_b_reg;
    assign min_b     = min_b_reg;
    assign mean_b    = mean_b_reg;

    `SRMMM_ASSERT(a_count_bounded, count_reg <= CNT_W'(DEPTH), "record count above depth")
    `SRMMM_ASSERT(a_ptr_tracks_count, count_reg == CNT_W'(DEPTH) || 32'(wp_reg) == 32'(count_reg), "write pointer differs from count before window is full")
    `SRMMM_ASSERT(a_extremes_ordered, count_reg == '0 || (smallest_a_reg <= largest_a_reg && smallest_b_reg <= largest_b_reg), "minimum above maximum in a nonempty record")
    `SRMMM_ASSERT_NEXT(a_clear_empties, in_accept && opcode == srmmm_pkg::OP_CLEAR, count_reg == '0 && sum_a_reg == '0 && sum_b_reg == '0, "clear item left record state")

endmodule
